/* hdl/scd_pkg.sv */
// Package for the sparse COO element-wise divide block.
// Holds the command codes, controller state type and status/command structs.
package scd_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_X = 2'd0,
    CMD_LOAD_Y = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DIV,
    ST_EMIT,
    ST_EMPTY
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load_x;
    logic load_y;
    logic adv_x;
    logic adv_y;
    logic div_go;   // start a division; another match follows the held one
    logic emit;     // capture a matched result
    logic emit_empty;
    logic set_last;
    logic clr_lists;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic x_full;
    logic y_full;
    logic walk_done;
    logic cmp_lt;
    logic cmp_gt;
    logic div_busy;
    logic out_full;
  } sts_t;

endpackage

/* hdl/sparse_coo_elementwise_divide.sv */
// Top level of the sparse COO element-wise divide block.
// Depends on scd_pkg, scd_ctrl, scd_dp, scd_div and scd_ram.
//
// Loads (cmd 0 for X, 1 for Y) and ignored commands are accepted in the idle state; a load
// into a full list is dropped and flagged. A run (cmd 2) walks both sorted lists:
// a compare step without a match passes the read and compare states, and a match
// goes on to wait in the divide state on the bit-serial divider (a zero divisor skips
// its iterations) and then the emit state, so the serial divider sets the run time.
// The walk ends with one more read state, plus the empty state when nothing matched.
// An emit waits until the previous result transaction has been taken. A matched
// result is held until the next match is found or the walk ends, so its last flag
// is known. Input is held off during a run.
module sparse_coo_elementwise_divide #(
  parameter int CAPACITY   = 64,
  parameter int MAX_MODES  = 4,
  parameter int INDEX_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        coord0_i,
  input  logic [31:0]        coord1_i,
  input  logic [31:0]        coord2_i,
  input  logic [31:0]        coord3_i,
  input  logic signed [31:0] entry_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        out_coord0_o,
  output logic [31:0]        out_coord1_o,
  output logic [31:0]        out_coord2_o,
  output logic [31:0]        out_coord3_o,
  output logic signed [31:0] quotient_o,
  output logic               zero_divisor_o,
  output logic               has_match_o,
  output logic               load_overflow_o,
  output logic               last_o
);
  import scd_pkg::*;

  ctl_t       ctl;
  sts_t       sts;
  logic [2:0] mode_count_q;
  logic       in_rdy;

  // Mode count register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= 3'd3;
    end else if (cfg_valid_i) begin
      mode_count_q <= cfg_data_i;
    end
  end

  scd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .cmd_i, .in_ready_o(in_rdy),
    .sts_i(sts), .ctl_o(ctl));
  assign in_ready_o = in_rdy;

  scd_dp #(.Capacity(CAPACITY), .MaxModes(MAX_MODES), .IndexBits(INDEX_BITS)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts), .mode_count_i(mode_count_q),
    .coord0_i, .coord1_i, .coord2_i, .coord3_i, .entry_value_i,
    .out_valid_o, .out_ready_i, .out_coord0_o, .out_coord1_o, .out_coord2_o,
    .out_coord3_o, .quotient_o, .zero_divisor_o, .has_match_o, .load_overflow_o,
    .last_o);

  // No input transaction is taken while a result that is not the last is pending.
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o) else $error("input taken mid-run");
  // An empty result is always the last one.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_match_o |-> last_o) else $error("empty result not last");
endmodule

/* hdl/scd_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module scd_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Read data is registered; a read during a write returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

/* hdl/scd_div.sv */
// Restoring signed divider, one quotient bit per cycle, with Q16.16 saturation.
// Depends on nothing outside this file.
module scd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  output logic               busy_o,
  output logic [31:0]        q_o,
  output logic               zero_o
);
  logic [47:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;
  logic        xneg_q, xneg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;
  logic [47:0] xabs;
  logic [31:0] yabs;
  logic [47:0] mag;
  logic [31:0] qsat;

  assign xabs = x_i[31] ? 48'(-{{16{x_i[31]}}, x_i}) << 16 : 48'({16'd0, x_i}) << 16;
  assign yabs = y_i[31] ? 32'(-y_i) : 32'(y_i);
  assign trial = {rem_q[31:0], num_q[47]} - {1'b0, den_q};

  // Iteration: shift one numerator bit into the remainder per cycle.
  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; neg_d = neg_q;
    zero_d = zero_q; xneg_d = xneg_q; cnt_d = cnt_q; busy_d = busy_q;
    if (go_i) begin
      num_d = xabs; rem_d = '0; den_d = yabs;
      neg_d = x_i[31] ^ y_i[31]; xneg_d = x_i[31];
      zero_d = (y_i == 32'sd0); cnt_d = 6'd48; busy_d = (y_i != 32'sd0);
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        num_d = {num_q[46:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], num_q[47]};
        num_d = {num_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      busy_d = (cnt_q != 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
    neg_q <= neg_d; zero_q <= zero_d; xneg_q <= xneg_d;
  end

  // Saturate the magnitude into signed 32 bits.
  assign mag = num_q;
  always_comb begin
    if (!neg_q) begin
      qsat = (mag > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      qsat = (mag > 48'h8000_0000) ? 32'h8000_0000 : 32'(-mag[31:0]);
    end
  end

  assign busy_o = busy_q;
  assign zero_o = zero_q;
  assign q_o = zero_q ? (xneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF) : qsat;
endmodule

/* hdl/scd_ctrl.sv */
// Controller state machine of the sparse COO divide block.
// Depends on scd_pkg.
module scd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     cmd_i,
  output logic           in_ready_o,
  input  scd_pkg::sts_t  sts_i,
  output scd_pkg::ctl_t  ctl_o
);
  import scd_pkg::*;

  state_e state_q, state_d;
  logic   any_q, any_d;
  logic   acc;

  assign acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      any_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      any_q   <= any_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    any_d = any_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && cmd_i == CMD_RUN) begin
          state_d = ST_READ;
          any_d = 1'b0;
        end
      end
      ST_READ: begin
        if (sts_i.walk_done) begin
          state_d = any_q ? ST_IDLE : ST_EMPTY;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts_i.cmp_lt || sts_i.cmp_gt) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_full) begin
          state_d = ST_READ;
          any_d = 1'b1;
        end
      end
      ST_EMPTY: begin
        if (!sts_i.out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.load_x = acc && cmd_i == CMD_LOAD_X;
        ctl_o.load_y = acc && cmd_i == CMD_LOAD_Y;
      end
      ST_READ: begin
        // With no match the lists stay until the empty result has taken the flag.
        ctl_o.set_last = sts_i.walk_done && any_q;
        ctl_o.clr_lists = sts_i.walk_done && any_q;
      end
      ST_CMP: begin
        ctl_o.adv_x = sts_i.cmp_lt;
        ctl_o.adv_y = sts_i.cmp_gt;
        ctl_o.div_go = !(sts_i.cmp_lt || sts_i.cmp_gt);
      end
      ST_DIV: ;
      ST_EMIT: begin
        ctl_o.emit = !sts_i.out_full;
        ctl_o.adv_x = !sts_i.out_full;
        ctl_o.adv_y = !sts_i.out_full;
      end
      ST_EMPTY: begin
        ctl_o.emit_empty = !sts_i.out_full;
        ctl_o.clr_lists = !sts_i.out_full;
      end
      default: ;
    endcase
  end
endmodule

/* hdl/scd_dp.sv */
// Datapath: entry memories, merge indices, comparator, divider and output register.
// Depends on scd_pkg, scd_ram and scd_div.
module scd_dp #(
  parameter int Capacity  = 64,
  parameter int MaxModes  = 4,
  parameter int IndexBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scd_pkg::ctl_t       ctl_i,
  output scd_pkg::sts_t       sts_o,
  input  logic [2:0]          mode_count_i,
  input  logic [31:0]         coord0_i,
  input  logic [31:0]         coord1_i,
  input  logic [31:0]         coord2_i,
  input  logic [31:0]         coord3_i,
  input  logic signed [31:0]  entry_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         out_coord0_o,
  output logic [31:0]         out_coord1_o,
  output logic [31:0]         out_coord2_o,
  output logic [31:0]         out_coord3_o,
  output logic signed [31:0]  quotient_o,
  output logic                zero_divisor_o,
  output logic                has_match_o,
  output logic                load_overflow_o,
  output logic                last_o
);
  import scd_pkg::*;

  localparam int AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CW = $clog2(Capacity + 1);
  localparam int RW = MaxModes * IndexBits + 32;

  logic [CW-1:0] xcnt_q, xcnt_d, ycnt_q, ycnt_d, xi_q, xi_d, yi_q, yi_d;
  logic          ovf_q, ovf_d;
  logic [RW-1:0] wrow, xrow, yrow;
  logic [AW-1:0] xaddr, yaddr;
  logic [31:0]   cin [4];
  logic [31:0]   xc [4];
  logic [31:0]   yc [4];
  logic [2:0]    m;
  logic          lt, gt;
  logic [31:0]   q;
  logic          zdiv, dbusy;
  logic          ov_q, ov_d, last_q, last_d, rel_q, rel_d, hm_q, zd_q, ovf_out_q;
  logic [31:0]   oc_q [4];
  logic [31:0]   quo_q;

  assign cin[0] = coord0_i; assign cin[1] = coord1_i;
  assign cin[2] = coord2_i; assign cin[3] = coord3_i;

  // Pack a row: coordinates of the stored modes, then the value.
  always_comb begin
    wrow = '0;
    for (int k = 0; k < MaxModes; k++) begin
      wrow[k*IndexBits +: IndexBits] = cin[k][IndexBits-1:0];
    end
    wrow[MaxModes*IndexBits +: 32] = entry_value_i;
  end

  assign xaddr = ctl_i.load_x ? xcnt_q[AW-1:0] : (ctl_i.adv_x ? AW'(xi_q + 1'b1) : xi_q[AW-1:0]);
  assign yaddr = ctl_i.load_y ? ycnt_q[AW-1:0] : (ctl_i.adv_y ? AW'(yi_q + 1'b1) : yi_q[AW-1:0]);

  scd_ram #(.Width(RW), .Depth(Capacity)) u_xram (
    .clk_i, .we_i(ctl_i.load_x && !sts_o.x_full), .addr_i(xaddr),
    .wdata_i(wrow), .rdata_o(xrow));
  scd_ram #(.Width(RW), .Depth(Capacity)) u_yram (
    .clk_i, .we_i(ctl_i.load_y && !sts_o.y_full), .addr_i(yaddr),
    .wdata_i(wrow), .rdata_o(yrow));

  // Unpack coordinates, zeroing modes not stored.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xc[k] = '0;
      yc[k] = '0;
      if (k < MaxModes) begin
        xc[k] = 32'(xrow[k*IndexBits +: IndexBits]);
        yc[k] = 32'(yrow[k*IndexBits +: IndexBits]);
      end
    end
  end

  assign m = (mode_count_i == 3'd0) ? 3'd1 :
             (mode_count_i > 3'(MaxModes)) ? 3'(MaxModes) : mode_count_i;

  // Lexicographic compare over the active modes, mode 0 first.
  always_comb begin
    lt = 1'b0;
    gt = 1'b0;
    for (int k = 3; k >= 0; k--) begin
      if (3'(k) < m && xc[k] != yc[k]) begin
        lt = xc[k] < yc[k];
        gt = xc[k] > yc[k];
      end
    end
  end

  scd_div u_div (
    .clk_i, .rst_ni, .go_i(ctl_i.div_go),
    .x_i(xrow[RW-1 -: 32]), .y_i(yrow[RW-1 -: 32]),
    .busy_o(dbusy), .q_o(q), .zero_o(zdiv));

  // Counters and walk indices.
  always_comb begin
    xcnt_d = xcnt_q; ycnt_d = ycnt_q; xi_d = xi_q; yi_d = yi_q; ovf_d = ovf_q;
    if (ctl_i.load_x) begin
      if (sts_o.x_full) ovf_d = 1'b1; else xcnt_d = xcnt_q + 1'b1;
    end
    if (ctl_i.load_y) begin
      if (sts_o.y_full) ovf_d = 1'b1; else ycnt_d = ycnt_q + 1'b1;
    end
    if (ctl_i.adv_x) xi_d = xi_q + 1'b1;
    if (ctl_i.adv_y) yi_d = yi_q + 1'b1;
    if (ctl_i.clr_lists) begin
      xcnt_d = '0; ycnt_d = '0; xi_d = '0; yi_d = '0; ovf_d = 1'b0;
    end
  end

  // Output register: valid, last flag and release. A matched result is held
  // back until the walk finds another match or ends, which decides its last flag.
  always_comb begin
    ov_d = ov_q;
    last_d = last_q;
    rel_d = rel_q;
    if (out_valid_o && out_ready_i) ov_d = 1'b0;
    if (ctl_i.div_go) rel_d = 1'b1;
    if (ctl_i.emit || ctl_i.emit_empty) begin
      ov_d = 1'b1;
      last_d = ctl_i.emit_empty;
      rel_d = ctl_i.emit_empty;
    end
    if (ctl_i.set_last) begin
      last_d = 1'b1;
      rel_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xcnt_q <= '0; ycnt_q <= '0; xi_q <= '0; yi_q <= '0; ovf_q <= 1'b0;
      ov_q <= 1'b0; last_q <= 1'b0; rel_q <= 1'b0;
    end else begin
      xcnt_q <= xcnt_d; ycnt_q <= ycnt_d; xi_q <= xi_d; yi_q <= yi_d; ovf_q <= ovf_d;
      ov_q <= ov_d; last_q <= last_d; rel_q <= rel_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (ctl_i.emit || ctl_i.emit_empty) begin
      for (int k = 0; k < 4; k++) begin
        oc_q[k] <= (ctl_i.emit && 3'(k) < m) ? xc[k] : 32'd0;
      end
      quo_q     <= ctl_i.emit ? q : 32'd0;
      zd_q      <= ctl_i.emit && zdiv;
      hm_q      <= ctl_i.emit;
      ovf_out_q <= ovf_q;
    end
  end

  // Status to the controller.
  assign sts_o.x_full    = (xcnt_q == CW'(Capacity));
  assign sts_o.y_full    = (ycnt_q == CW'(Capacity));
  assign sts_o.walk_done = (xi_q >= xcnt_q) || (yi_q >= ycnt_q);
  assign sts_o.cmp_lt    = lt;
  assign sts_o.cmp_gt    = gt;
  assign sts_o.div_busy  = dbusy;
  assign sts_o.out_full  = ov_q;

  assign out_valid_o     = ov_q && rel_q;
  assign out_coord0_o    = oc_q[0];
  assign out_coord1_o    = oc_q[1];
  assign out_coord2_o    = oc_q[2];
  assign out_coord3_o    = oc_q[3];
  assign quotient_o      = quo_q;
  assign zero_divisor_o  = zd_q;
  assign has_match_o     = hm_q;
  assign load_overflow_o = ovf_out_q;
  assign last_o          = last_q;
endmodule

/* test/tb_sparse_coo_elementwise_divide.sv */
// Testbench for the sparse COO element-wise divide block.
// Depends on scd_pkg and sparse_coo_elementwise_divide; predicts every result
// transaction with its own merge-walk model and checks them in order.
module tb_sparse_coo_elementwise_divide;
  import scd_pkg::*;

  localparam int Capacity = 64;
  localparam int MaxModes = 4;

  typedef struct packed {
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    logic [31:0] quot;
    logic        zdiv;
    logic        hit;
    logic        ovf;
    logic        lst;
  } quot_rec_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [2:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [1:0] cmd_i;
  logic [31:0] coord0_i, coord1_i, coord2_i, coord3_i;
  logic signed [31:0] entry_value_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [31:0] out_coord0_o, out_coord1_o, out_coord2_o, out_coord3_o;
  logic signed [31:0] quotient_o;
  logic zero_divisor_o, has_match_o, load_overflow_o, last_o;

  sparse_coo_elementwise_divide uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cmd_i, .coord0_i, .coord1_i, .coord2_i,
    .coord3_i, .entry_value_i, .out_valid_o, .out_ready_i, .out_coord0_o,
    .out_coord1_o, .out_coord2_o, .out_coord3_o, .quotient_o,
    .zero_divisor_o, .has_match_o, .load_overflow_o, .last_o
  );

  // Predictor state: a copy of both lists and the mode count.
  logic [2:0]  modes_reg;
  logic [31:0] xs_coord[Capacity][MaxModes];
  logic [31:0] ys_coord[Capacity][MaxModes];
  logic [31:0] xs_val[Capacity];
  logic [31:0] ys_val[Capacity];
  int          xs_cnt, ys_cnt;
  logic        ovf_flag;

  quot_rec_t   pending_q[$];
  int          err_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_recv;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Fixed-point divide with saturation and zero-divisor handling.
  function automatic logic [31:0] q16_divide(logic [31:0] xv, logic [31:0] yv,
                                            output logic zflag);
    longint xn, yn, qn;
    xn = longint'($signed(xv));
    yn = longint'($signed(yv));
    zflag = 1'b0;
    if (yn == 0) begin
      zflag = 1'b1;
      return (xn < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    qn = (xn * 65536) / yn;
    if (qn > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (qn < -64'sd2147483648) return 32'h8000_0000;
    return qn[31:0];
  endfunction

  // Lexicographic compare of one X entry against one Y entry.
  function automatic int order_xy(int i, int j, int m);
    for (int k = 0; k < m; k++) begin
      if (xs_coord[i][k] < ys_coord[j][k]) return -1;
      if (xs_coord[i][k] > ys_coord[j][k]) return 1;
    end
    return 0;
  endfunction

  // Apply one accepted command to the predictor and queue its results.
  task automatic predict_cmd(cmd_e cmd, logic [31:0] c[MaxModes], logic [31:0] v);
    int m, i, j, n, r;
    quot_rec_t rec;
    logic z;
    if (cmd == CMD_LOAD_X || cmd == CMD_LOAD_Y) begin
      if ((cmd == CMD_LOAD_X ? xs_cnt : ys_cnt) >= Capacity) begin
        ovf_flag = 1'b1;
      end else if (cmd == CMD_LOAD_X) begin
        for (int k = 0; k < MaxModes; k++) xs_coord[xs_cnt][k] = c[k];
        xs_val[xs_cnt] = v;
        xs_cnt++;
      end else begin
        for (int k = 0; k < MaxModes; k++) ys_coord[ys_cnt][k] = c[k];
        ys_val[ys_cnt] = v;
        ys_cnt++;
      end
    end else if (cmd == CMD_RUN) begin
      m = (modes_reg == 0) ? 1 : (modes_reg > MaxModes) ? MaxModes : modes_reg;
      i = 0;
      j = 0;
      n = 0;
      while (i < xs_cnt && j < ys_cnt && n < Capacity) begin
        r = order_xy(i, j, m);
        if (r > 0) j++;
        else if (r < 0) i++;
        else begin
          rec = '0;
          rec.c0 = xs_coord[i][0];
          rec.c1 = (m > 1) ? xs_coord[i][1] : 32'd0;
          rec.c2 = (m > 2) ? xs_coord[i][2] : 32'd0;
          rec.c3 = (m > 3) ? xs_coord[i][3] : 32'd0;
          rec.quot = q16_divide(xs_val[i], ys_val[j], z);
          rec.zdiv = z;
          rec.hit = 1'b1;
          rec.ovf = ovf_flag;
          rec.lst = (i + 1 >= xs_cnt) || (j + 1 >= ys_cnt) || (n + 1 >= Capacity);
          pending_q.push_back(rec);
          n++;
          i++;
          j++;
        end
      end
      // The last flag is only known once the walk ends: fix up the tail.
      if (n == 0) begin
        rec = '0;
        rec.ovf = ovf_flag;
        rec.lst = 1'b1;
        pending_q.push_back(rec);
      end else begin
        for (int k = pending_q.size() - n; k < pending_q.size(); k++)
          pending_q[k].lst = (k == pending_q.size() - 1);
      end
      xs_cnt = 0;
      ys_cnt = 0;
      ovf_flag = 1'b0;
    end
  endtask

  // Send one command transaction, idling at random before it. Valid stays high
  // after acceptance until the next send or the drain takes it over.
  task automatic send_entry(cmd_e cmd, logic [31:0] c0, logic [31:0] c1,
                            logic [31:0] c2, logic [31:0] c3, logic [31:0] v);
    logic [31:0] cv[MaxModes];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cv[0] = c0;
    cv[1] = c1;
    cv[2] = c2;
    cv[3] = c3;
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    coord0_i <= c0;
    coord1_i <= c1;
    coord2_i <= c2;
    coord3_i <= c3;
    entry_value_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_cmd(cmd, cv, v);
  endtask

  // Wait until all results are in, then let the block settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write the mode count while the block is idle.
  task automatic write_modes(logic [2:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    modes_reg = val;
    cfg_valid_i <= 1'b0;
  endtask

  // Random 32-bit value with a bias toward the extremes.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Coordinates from a tiny alphabet so the two lists share many entries.
  function automatic logic [31:0] pick_coord(int k);
    if ($urandom_range(9) == 0) return $urandom();
    return $urandom_range(3) + (k == 0 ? 32'd0 : 32'hFFFF_FFFC * $urandom_range(1));
  endfunction

  // Directed cases: extremes, every command, zero divisor, empty run.
  task automatic test_directed();
    send_entry(CMD_LOAD_X, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000);
    send_entry(CMD_LOAD_X, 32'd1, 32'd2, 32'd3, 32'd4, 32'h8000_0000);
    send_entry(CMD_LOAD_X, 32'd5, 32'd0, 32'd0, 32'd0, 32'hFFFF_0000);
    send_entry(CMD_LOAD_X, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_entry(CMD_LOAD_Y, 32'd0, 32'd0, 32'd0, 32'd9, 32'h0000_0003);
    send_entry(CMD_LOAD_Y, 32'd1, 32'd2, 32'd3, 32'd4, 32'h0000_0000);
    send_entry(CMD_LOAD_Y, 32'd5, 32'd0, 32'd0, 32'd0, 32'h0000_0000);
    send_entry(CMD_LOAD_Y, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_entry(CMD_NONE, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
    send_entry(CMD_RUN, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    // No matches at all.
    send_entry(CMD_LOAD_X, 32'd7, 32'd0, 32'd0, 32'd0, 32'h0000_0001);
    send_entry(CMD_LOAD_Y, 32'd8, 32'd0, 32'd0, 32'd0, 32'h0000_0001);
    send_entry(CMD_RUN, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_entry(CMD_RUN, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    drain_results();
  endtask

  // Fill X past capacity so the overflow flag is raised and reported.
  task automatic test_overflow();
    for (int n = 0; n < Capacity + 3; n++)
      send_entry(CMD_LOAD_X, n, 32'd0, 32'd0, 32'd0, $urandom());
    for (int n = 0; n < Capacity; n += 2)
      send_entry(CMD_LOAD_Y, n, 32'd0, 32'd0, 32'd0, $urandom());
    send_entry(CMD_RUN, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    drain_results();
  endtask

  // Random sorted-ish lists with random content, plus some noise.
  task automatic test_random(int n_items);
    int sent, nx, ny;
    logic [31:0] cur;
    sent = 0;
    while (sent < n_items) begin
      nx = $urandom_range(12);
      ny = $urandom_range(12);
      cur = $urandom_range(3);
      for (int n = 0; n < nx; n++) begin
        cur += $urandom_range(2);
        send_entry(CMD_LOAD_X, ($urandom_range(19) == 0) ? pick_word() : cur,
                   pick_coord(1), pick_coord(2), pick_coord(3), pick_word());
      end
      cur = $urandom_range(3);
      for (int n = 0; n < ny; n++) begin
        cur += $urandom_range(2);
        send_entry(CMD_LOAD_Y, cur, pick_coord(1), pick_coord(2), pick_coord(3),
                   ($urandom_range(9) == 0) ? 32'd0 : pick_word());
      end
      if ($urandom_range(9) == 0)
        send_entry(CMD_NONE, pick_word(), pick_word(), pick_word(), pick_word(),
                   pick_word());
      send_entry(CMD_RUN, pick_word(), pick_word(), pick_word(), pick_word(),
                 pick_word());
      sent += nx + ny + 1;
    end
    drain_results();
  endtask

  // Long receiver hold-off while the sender keeps issuing runs.
  task automatic test_backpressure();
    hold_recv = 1'b1;
    for (int n = 0; n < 6; n++) begin
      send_entry(CMD_LOAD_X, n, 32'd1, 32'd1, 32'd1, $urandom());
      send_entry(CMD_LOAD_Y, n, 32'd1, 32'd1, 32'd1, $urandom());
      send_entry(CMD_RUN, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    end
    drain_results();
  endtask

  // Receiver: random stalls, plus a counted hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_recv) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: compare each transaction with the oldest prediction.
  initial begin
    quot_rec_t got, exp_rec;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = {out_coord0_o, out_coord1_o, out_coord2_o, out_coord3_o, quotient_o,
               zero_divisor_o, has_match_o, load_overflow_o, last_o};
        if (pending_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("Unexpected result transaction: %h", got);
        end else begin
          exp_rec = pending_q.pop_front();
          if (got !== exp_rec) begin
            err_count++;
            if (err_count <= 10)
              $display("Result mismatch: expected %h, actual %h", exp_rec, got);
          end
        end
      end
    end
  end

  // Run limit.
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 3'd0;
    in_valid_i = 1'b0;
    cmd_i = CMD_NONE;
    coord0_i = '0;
    coord1_i = '0;
    coord2_i = '0;
    coord3_i = '0;
    entry_value_i = '0;
    hold_recv = 1'b0;
    err_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    modes_reg = 3'd3;
    xs_cnt = 0;
    ys_cnt = 0;
    ovf_flag = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_modes(3'd4);
    test_directed();
    write_modes(3'd0);
    test_overflow();
    test_backpressure();
    write_modes(3'd1);
    test_random(75);
    send_idle_pct = 75;
    write_modes(3'd2);
    test_random(75);
    send_idle_pct = 0;
    recv_stall_pct = 75;
    write_modes(3'd7);
    test_random(75);
    send_idle_pct = 14;
    recv_stall_pct = 14;
    write_modes(3'd3);
    test_random(75);

    if (err_count == 0 && pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
